>>> src/fisr_pkg.sv
// shared constants and helper functions for the reciprocal square root pipeline
`default_nettype none
package fisr_pkg;

  localparam logic [31:0] MAGIC_WORD   = 32'h5F3759DF;
  localparam logic [31:0] HALF_BITS    = 32'h3F000000;
  localparam logic [31:0] THREE_HALVES = 32'h3FC00000;
  localparam logic [31:0] CANON_NAN    = 32'h7FC00000;
  localparam logic [30:0] INF_MAG      = 31'h7F800000;
  localparam int          LATENCY      = 10;
  localparam int          Y_DEPTH      = 8;

  // leading zero count of a 48-bit word, word assumed nonzero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // leading zero count of a 27-bit word, word assumed nonzero
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> src/fisr_fmul.sv
// two-stage binary32 multiplier, round to nearest even, subnormals kept
`default_nettype none
module fisr_fmul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             out_valid,
  output logic [31:0]      res
);

  logic [7:0]  ea, eb, ea_eff, eb_eff;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [23:0] ma, mb;

  logic               s1_valid, s1_sign, s1_nan, s1_inf, s1_zero;
  logic signed [10:0] s1_exp;
  logic [47:0]        s1_prod;

  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    nan_a  = (ea == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (eb == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (ea == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (eb == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (ea == 8'd0) && (a[22:0] == 23'd0);
    zero_b = (eb == 8'd0) && (b[22:0] == 23'd0);
    ea_eff = (ea == 8'd0) ? 8'd1 : ea;
    eb_eff = (eb == 8'd0) ? 8'd1 : eb;
    ma     = {ea != 8'd0, a[22:0]};
    mb     = {eb != 8'd0, b[22:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_sign <= a[31] ^ b[31];
    s1_nan  <= nan_a | nan_b | (inf_a & zero_b) | (zero_a & inf_b);
    s1_inf  <= inf_a | inf_b;
    s1_zero <= zero_a | zero_b;
    s1_exp  <= $signed({3'b000, ea_eff}) + $signed({3'b000, eb_eff}) - 11'sd127;
    s1_prod <= ma * mb;
  end

  // stage 2: normalize, denormalize on underflow, round
  logic [5:0]         lz;
  logic [47:0]        pn, shv;
  logic signed [10:0] e_norm;
  logic [10:0]        rs;
  logic [30:0]        word;
  logic               grd, stk, lost, inc;
  logic [31:0]        res_next;

  always_comb begin
    lz     = fisr_pkg::lzc48(s1_prod);
    pn     = s1_prod << lz;
    e_norm = s1_exp + 11'sd1 - $signed({5'd0, lz});
    rs     = 11'd0;
    shv    = pn;
    lost   = 1'b0;
    if (e_norm >= 11'sd1) begin
      word = {e_norm[7:0], pn[46:24]};
      grd  = pn[23];
      stk  = |pn[22:0];
    end else begin
      rs = 11'd1 - e_norm;
      if (rs >= 11'd48) begin
        shv  = 48'd0;
        lost = |pn;
      end else begin
        shv  = pn >> rs[5:0];
        lost = ((shv << rs[5:0]) != pn);
      end
      word = {8'd0, shv[46:24]};
      grd  = shv[23];
      stk  = (|shv[22:0]) | lost;
    end
    inc = grd & (stk | word[0]);
    if (s1_nan) begin
      res_next = fisr_pkg::CANON_NAN;
    end else if (s1_inf || (e_norm >= 11'sd255)) begin
      res_next = {s1_sign, fisr_pkg::INF_MAG};
    end else if (s1_zero) begin
      res_next = {s1_sign, 31'd0};
    end else begin
      res_next = {s1_sign, word + {30'd0, inc}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    res <= res_next;
  end

endmodule
`default_nettype wire

>>> src/fisr_fadd.sv
// two-stage binary32 adder, round to nearest even, subnormals kept
`default_nettype none
module fisr_fadd (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             out_valid,
  output logic [31:0]      res
);

  logic        nan_a, nan_b, inf_a, inf_b, swap;
  logic [31:0] big, sml;
  logic [7:0]  eb_eff, es_eff, d;
  logic [26:0] mbig, msml, msh, msml_sh;

  logic        s1_valid, s1_sign, s1_sub, s1_nan, s1_inf, s1_inf_sign, s1_zsign;
  logic [7:0]  s1_exp;
  logic [26:0] s1_ma, s1_mb;

  always_comb begin
    nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    swap   = b[30:0] > a[30:0];
    big    = swap ? b : a;
    sml    = swap ? a : b;
    eb_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es_eff = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d      = eb_eff - es_eff;
    mbig   = {big[30:23] != 8'd0, big[22:0], 3'b000};
    msml   = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      msml_sh = {26'd0, |msml};
      msh     = 27'd0;
    end else begin
      msh     = msml >> d[4:0];
      msml_sh = {msh[26:1], msh[0] | ((msh << d[4:0]) != msml)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_sign     <= big[31];
    s1_sub      <= a[31] ^ b[31];
    s1_nan      <= nan_a | nan_b | (inf_a & inf_b & (a[31] ^ b[31]));
    s1_inf      <= inf_a | inf_b;
    s1_inf_sign <= inf_a ? a[31] : b[31];
    s1_zsign    <= a[31] & b[31];
    s1_exp      <= eb_eff;
    s1_ma       <= mbig;
    s1_mb       <= msml_sh;
  end

  // stage 2: add, normalize with the shift capped at the subnormal floor, round
  logic [27:0] sum;
  logic [26:0] n;
  logic [4:0]  lz;
  logic [7:0]  sh;
  logic [8:0]  e2, efield;
  logic [30:0] word;
  logic        inc;
  logic [31:0] res_next;

  always_comb begin
    sum = s1_sub ? ({1'b0, s1_ma} - {1'b0, s1_mb}) : ({1'b0, s1_ma} + {1'b0, s1_mb});
    lz  = fisr_pkg::lzc27(sum[26:0]);
    sh  = 8'd0;
    if (sum[27]) begin
      n  = {sum[27:2], sum[1] | sum[0]};
      e2 = {1'b0, s1_exp} + 9'd1;
    end else begin
      sh = ({3'd0, lz} < (s1_exp - 8'd1)) ? {3'd0, lz} : (s1_exp - 8'd1);
      n  = sum[26:0] << sh[4:0];
      e2 = {1'b0, s1_exp} - {1'b0, sh};
    end
    efield = n[26] ? e2 : 9'd0;
    word   = {efield[7:0], n[25:3]};
    inc    = n[2] & (n[1] | n[0] | n[3]);
    if (s1_nan) begin
      res_next = fisr_pkg::CANON_NAN;
    end else if (s1_inf) begin
      res_next = {s1_inf_sign, fisr_pkg::INF_MAG};
    end else if (sum == 28'd0) begin
      res_next = {s1_zsign, 31'd0};
    end else if (efield >= 9'd255) begin
      res_next = {s1_sign, fisr_pkg::INF_MAG};
    end else begin
      res_next = {s1_sign, word + {30'd0, inc}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    res <= res_next;
  end

endmodule
`default_nettype wire

>>> src/fast_inverse_sqrt_unit.sv
// top level: magic-constant guess and one newton step as a ten-stage pipeline
//
//   channel   ports                      handshake
//   command   start, busy, operand_bits  beat taken when start & !busy
//   result    done, result_bits          one-cycle strobe, cannot be held off
//
// every beat runs from start to done through five float units of two stages each
// (half, x2*y, *y, 1.5-t2, y*t3) in series, the guess word riding a delay line beside them.
// a new beat can enter every cycle; busy stays low.
// synchronous reset clears only the valid bits along the pipeline.
// the receiver cannot stall, so nothing in the pipeline ever holds.
`default_nettype none
module fast_inverse_sqrt_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] operand_bits,
  output logic             done,
  output logic [31:0]      result_bits
);

  logic        accept;
  logic [31:0] guess;
  logic [31:0] ydly [fisr_pkg::Y_DEPTH];
  logic        v_half, v_t1, v_t2, v_t3;
  logic [31:0] half, t1, t2, t3;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  // arithmetic shift of the word, wrapping subtract
  assign guess  = fisr_pkg::MAGIC_WORD - {operand_bits[31], operand_bits[31:1]};

  always_ff @(posedge clk) begin
    ydly[0] <= guess;
    for (int i = 1; i < fisr_pkg::Y_DEPTH; i++) begin
      ydly[i] <= ydly[i-1];
    end
  end

  fisr_fmul u_half (
    .clk(clk), .rst(rst), .in_valid(accept), .a(operand_bits), .b(fisr_pkg::HALF_BITS),
    .out_valid(v_half), .res(half)
  );

  fisr_fmul u_t1 (
    .clk(clk), .rst(rst), .in_valid(v_half), .a(half), .b(ydly[1]),
    .out_valid(v_t1), .res(t1)
  );

  fisr_fmul u_t2 (
    .clk(clk), .rst(rst), .in_valid(v_t1), .a(t1), .b(ydly[3]),
    .out_valid(v_t2), .res(t2)
  );

  // 1.5 - t2 as 1.5 + (-t2)
  fisr_fadd u_t3 (
    .clk(clk), .rst(rst), .in_valid(v_t2), .a(fisr_pkg::THREE_HALVES),
    .b({~t2[31], t2[30:0]}), .out_valid(v_t3), .res(t3)
  );

  fisr_fmul u_r (
    .clk(clk), .rst(rst), .in_valid(v_t3), .a(ydly[7]), .b(t3),
    .out_valid(done), .res(result_bits)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##10 done) else $error("beat did not arrive after ten cycles");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 10)) else $error("result without a command beat");

  a_nan_in: assert property (@(posedge clk) disable iff (rst)
    (accept && operand_bits[30:23] == 8'hFF && operand_bits[22:0] != 23'd0)
    |-> ##10 (result_bits == fisr_pkg::CANON_NAN))
    else $error("nan operand did not give the canonical nan");

endmodule
`default_nettype wire
